FILE: src/assert_macros.svh
// Assertion macros shared by the dimmer command handler modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DCPH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("dcph assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define DCPH_NEVER(lbl, clk, rstn, cond) `DCPH_ASSERT(lbl, clk, rstn, !(cond))

`endif

FILE: src/dcph_pkg.sv
// Package for the dimmer command packet handler: codes, sizes, op and result types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcph_pkg;

    localparam int ID_BYTES = 4;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << (8 * ID_BYTES)) - 64'd1);
    localparam int ADDR_SHIFT = 32 - 8 * ID_BYTES;

    localparam logic [7:0] LEN_MIN   = 8'(4 + ID_BYTES);
    localparam logic [7:0] LEN_CTRL  = 8'(5 + ID_BYTES);
    localparam logic [7:0] LEN_SETUP = 8'(4 + 2 * ID_BYTES);

    localparam logic [7:0] CMD_FIRST     = 8'h01;
    localparam logic [7:0] CMD_LAST_BASE = 8'h0b;
    localparam logic [7:0] CMD_DIM       = 8'h04;
    localparam logic [7:0] CMD_ADDR      = 8'h08;
    localparam logic [7:0] CMD_PAIR      = 8'h10;
    localparam logic [7:0] CMD_SEARCH    = 8'h11;

    localparam logic [7:0] PKT_CONTROL = 8'h01;
    localparam logic [7:0] PKT_QUERY   = 8'h02;
    localparam logic [7:0] PKT_SETUP   = 8'h55;

    localparam logic [7:0] SRC_BT  = 8'h01;
    localparam logic [7:0] SRC_BOX = 8'h03;

    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STS_SHORT       = 2'd2;
    localparam logic [1:0] STS_NOT_OURS    = 2'd3;

    localparam logic [1:0] REPLY_NONE   = 2'd0;
    localparam logic [1:0] REPLY_ADDR   = 2'd1;
    localparam logic [1:0] REPLY_PAIR   = 2'd2;
    localparam logic [1:0] REPLY_SEARCH = 2'd3;

    localparam logic [1:0] PAIR_PAIRED   = 2'd1;
    localparam logic [1:0] PAIR_UNPAIRED = 2'd2;

    localparam logic [1:0] LVL_MINUTE = 2'd1;
    localparam logic [1:0] LVL_DAY    = 2'd2;
    localparam logic [1:0] LVL_YEAR   = 2'd3;

    localparam logic [31:0] OWN_ADDR_RESET = 32'd1;

    localparam int DLY_W = 13;
    localparam logic [15:0] DIV100_MUL = 16'd41944;
    localparam int DIV100_SHIFT = 22;
    localparam logic [6:0] HUNDRED = 7'd100;

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef enum logic [3:0] {
        CL_NOP,
        CL_TICK,
        CL_REJ,
        CL_SHORT,
        CL_UNHANDLED,
        CL_DIM,
        CL_ADDR_SET,
        CL_ADDR_QUERY,
        CL_PAIR_SET,
        CL_PAIR_QUERY,
        CL_SEARCH
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [1:0]  status;
        logic [31:0] dest;
        logic [7:0]  src;
        logic [7:0]  data;
        logic [31:0] new_addr;
    } t_op;

    typedef struct packed {
        logic [1:0]  status;
        logic        pwm_valid;
        logic [7:0]  pwm_level;
        logic        save_request;
        logic [1:0]  reply_kind;
        logic [7:0]  reply_cmd;
        logic [31:0] reply_id;
        logic [7:0]  reply_source;
        logic [1:0]  reply_value;
        logic [7:0]  reply_length;
        logic [6:0]  reply_wait_ms;
    } t_res;

endpackage

FILE: src/dcph_front.sv
// Front end: accepts stream items and classifies them into queued ops.
// Depends on dcph_pkg; feeds dcph_fifo.
`timescale 1ns / 1ps

module dcph_front (
    input  logic               i_valid,
    input  logic [95:0]        i_data,
    input  logic               i_user,
    output logic               o_ready,
    input  logic               i_full,
    output logic               o_push,
    output dcph_pkg::t_op      o_op
);
    import dcph_pkg::*;

    logic [7:0]  cmd;
    logic [7:0]  pkt_state;
    logic [31:0] dest_id;
    logic [7:0]  source;
    logic [31:0] payload;
    logic [7:0]  packet_len;
    logic [7:0]  d0;
    logic        supported;

    assign cmd        = i_data[7:0];
    assign pkt_state  = i_data[15:8];
    assign dest_id    = i_data[47:16];
    assign source     = i_data[55:48];
    assign payload    = i_data[87:56];
    assign packet_len = i_data[95:88];
    assign d0         = payload[31:24];

    assign supported = (cmd >= CMD_FIRST && cmd <= CMD_LAST_BASE) ||
                       cmd == CMD_PAIR || cmd == CMD_SEARCH;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_op          = '0;
        o_op.cls      = CL_NOP;
        o_op.status   = STS_OK;
        o_op.dest     = dest_id & ADDR_MASK;
        o_op.src      = source;
        o_op.data     = d0;
        o_op.new_addr = (payload >> ADDR_SHIFT) & ADDR_MASK;
        if (i_user) begin
            o_op.cls = CL_TICK;
        end else if (!supported) begin
            o_op.cls    = CL_REJ;
            o_op.status = STS_UNSUPPORTED;
        end else if (packet_len < LEN_MIN) begin
            o_op.cls    = CL_REJ;
            o_op.status = STS_SHORT;
        end else begin
            unique case (cmd)
                CMD_DIM: begin
                    if (pkt_state == PKT_CONTROL) begin
                        o_op.cls = (packet_len < LEN_CTRL) ? CL_SHORT : CL_DIM;
                    end
                end
                CMD_ADDR: begin
                    if (pkt_state == PKT_SETUP) begin
                        o_op.cls = (packet_len < LEN_SETUP) ? CL_SHORT : CL_ADDR_SET;
                    end else if (pkt_state == PKT_QUERY) begin
                        o_op.cls = CL_ADDR_QUERY;
                    end
                end
                CMD_PAIR: begin
                    if (pkt_state == PKT_CONTROL) begin
                        if (packet_len < LEN_CTRL) begin
                            o_op.cls = CL_SHORT;
                        end else if (d0 == 8'(PAIR_PAIRED) || d0 == 8'(PAIR_UNPAIRED)) begin
                            o_op.cls = CL_PAIR_SET;
                        end
                    end else if (pkt_state == PKT_QUERY) begin
                        o_op.cls = CL_PAIR_QUERY;
                    end
                end
                CMD_SEARCH: begin
                    if (pkt_state == PKT_QUERY && source != SRC_BT &&
                        d0 >= 8'(LVL_MINUTE) && d0 <= 8'(LVL_YEAR)) begin
                        o_op.cls = CL_SEARCH;
                    end
                end
                default: begin
                    o_op.cls = CL_UNHANDLED;
                end
            endcase
        end
    end

endmodule

FILE: src/dcph_fifo.sv
// Short op queue between the classifying front and the executing back.
// Depends on dcph_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcph_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dcph_pkg::t_op      i_op,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output dcph_pkg::t_op      o_op
);
    import dcph_pkg::*;

    t_op              r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_count;
    logic [QAW-1:0]   n_wr;
    logic [QAW-1:0]   n_rd;
    logic [QAW:0]     n_count;

    assign o_full  = (r_count == (QAW + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    `DCPH_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `DCPH_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid)
    `DCPH_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)

endmodule

FILE: src/dcph_back.sv
// Back end: owns the device state, executes queued ops, registers one result per op.
// Depends on dcph_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcph_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  dcph_pkg::t_op      i_op,
    output logic               o_pop,
    output logic               o_res_valid,
    output dcph_pkg::t_res     o_res,
    input  logic               i_res_ready
);
    import dcph_pkg::*;

    logic [31:0]       r_own_address;
    logic [1:0]        r_pair_mark;
    logic              r_search_active;
    logic [6:0]        r_search_count;
    logic [6:0]        r_search_rem;
    logic [1:0]        r_search_level;
    logic [1:0]        r_settle;
    logic [DLY_W-1:0]  r_d_min;
    logic [DLY_W-1:0]  r_d_day;
    logic [DLY_W-1:0]  r_d_year;
    logic [13:0]       r_qr_min;
    logic [13:0]       r_qr_day;
    logic [13:0]       r_qr_year;
    logic              r_out_valid;
    t_res              r_out;

    logic [31:0]       n_own_address;
    logic [1:0]        n_pair_mark;
    logic              n_search_active;
    logic [6:0]        n_search_count;
    logic [6:0]        n_search_rem;
    logic [1:0]        n_search_level;
    logic [1:0]        n_settle;
    logic              n_out_valid;
    t_res              res;
    logic              addr_match;
    logic [13:0]       qr_sel;

    function automatic logic [13:0] div100(input logic [DLY_W-1:0] d);
        logic [DLY_W+15:0] prod;
        logic [6:0]        q;
        logic [DLY_W-1:0]  q100;
        logic [DLY_W-1:0]  rem;
        prod = (DLY_W + 16)'(d) * (DLY_W + 16)'(DIV100_MUL);
        q    = prod[DIV100_SHIFT +: 7];
        q100 = (DLY_W'(q) << 6) + (DLY_W'(q) << 5) + (DLY_W'(q) << 2);
        rem  = d - q100;
        return {q, rem[6:0]};
    endfunction

    assign addr_match = (i_op.dest == r_own_address) || (i_op.dest == ADDR_MASK);
    assign o_pop = i_op_valid && (r_settle == '0) && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res = r_out;

    always_comb begin
        unique case (i_op.data[1:0])
            LVL_MINUTE: qr_sel = r_qr_min;
            LVL_DAY:    qr_sel = r_qr_day;
            default:    qr_sel = r_qr_year;
        endcase
    end

    always_comb begin
        n_own_address   = r_own_address;
        n_pair_mark     = r_pair_mark;
        n_search_active = r_search_active;
        n_search_count  = r_search_count;
        n_search_rem    = r_search_rem;
        n_search_level  = r_search_level;
        n_settle        = (r_settle != '0) ? r_settle - 1'b1 : r_settle;
        res             = '0;
        if (o_pop) begin
            if (i_op.cls == CL_TICK) begin
                if (r_search_active) begin
                    if (r_search_count == '0) begin
                        res.reply_kind    = REPLY_SEARCH;
                        res.reply_cmd     = CMD_SEARCH;
                        res.reply_id      = r_own_address;
                        res.reply_source  = SRC_BOX;
                        res.reply_value   = r_search_level;
                        res.reply_length  = LEN_CTRL;
                        res.reply_wait_ms = r_search_rem;
                        n_search_active   = 1'b0;
                    end else begin
                        n_search_count = r_search_count - 1'b1;
                    end
                end
            end else if (i_op.cls == CL_REJ) begin
                res.status = i_op.status;
            end else if (!addr_match) begin
                res.status = STS_NOT_OURS;
            end else begin
                unique case (i_op.cls)
                    CL_SHORT:     res.status = STS_SHORT;
                    CL_UNHANDLED: res.status = STS_UNSUPPORTED;
                    CL_DIM: begin
                        res.pwm_valid = 1'b1;
                        res.pwm_level = i_op.data;
                    end
                    CL_ADDR_SET: begin
                        n_own_address    = i_op.new_addr;
                        n_settle         = SETTLE_CYCLES;
                        res.save_request = 1'b1;
                    end
                    CL_ADDR_QUERY: begin
                        res.reply_kind   = REPLY_ADDR;
                        res.reply_cmd    = CMD_ADDR;
                        res.reply_id     = r_own_address;
                        res.reply_source = i_op.src;
                        res.reply_length = LEN_SETUP;
                    end
                    CL_PAIR_SET: begin
                        n_pair_mark      = i_op.data[1:0];
                        res.save_request = 1'b1;
                    end
                    CL_PAIR_QUERY: begin
                        res.reply_kind   = REPLY_PAIR;
                        res.reply_cmd    = CMD_PAIR;
                        res.reply_id     = r_own_address;
                        res.reply_source = i_op.src;
                        res.reply_value  = r_pair_mark;
                        res.reply_length = LEN_CTRL;
                    end
                    CL_SEARCH: begin
                        if (r_pair_mark != PAIR_PAIRED && !r_search_active) begin
                            n_search_count  = qr_sel[13:7];
                            n_search_rem    = qr_sel[6:0];
                            n_search_level  = i_op.data[1:0];
                            n_search_active = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= OWN_ADDR_RESET;
            r_pair_mark     <= PAIR_PAIRED;
            r_search_active <= 1'b0;
            r_search_count  <= '0;
            r_search_rem    <= '0;
            r_search_level  <= '0;
            r_settle        <= SETTLE_CYCLES;
            r_out_valid     <= 1'b0;
        end else begin
            r_own_address   <= n_own_address;
            r_pair_mark     <= n_pair_mark;
            r_search_active <= n_search_active;
            r_search_count  <= n_search_count;
            r_search_rem    <= n_search_rem;
            r_search_level  <= n_search_level;
            r_settle        <= n_settle;
            r_out_valid     <= n_out_valid;
        end
    end

    // search delays follow the stored address through the r_d_* and then the r_qr_* registers
    always_ff @(posedge i_clk) begin
        r_d_min   <= (DLY_W'(r_own_address[11:6]) * DLY_W'(60)
                      + DLY_W'(r_own_address[5:0])) << 1;
        r_d_day   <= (DLY_W'(r_own_address[21:17]) * DLY_W'(24)
                      + DLY_W'(r_own_address[16:12])) << 1;
        r_d_year  <= (DLY_W'(r_own_address[31:27]) * DLY_W'(12)
                      + DLY_W'(r_own_address[26:23])) << 1;
        r_qr_min  <= div100(r_d_min);
        r_qr_day  <= div100(r_d_day);
        r_qr_year <= div100(r_d_year);
        if (o_pop) begin
            r_out <= res;
        end
    end

    `DCPH_ASSERT(a_rem_range, i_clk, i_rst_n, r_search_active |-> (r_search_rem < HUNDRED))
    `DCPH_ASSERT(a_addr_settle, i_clk, i_rst_n, (o_pop && i_op.cls == CL_ADDR_SET && addr_match) |=> r_settle == SETTLE_CYCLES)
    `DCPH_ASSERT(a_result_on_pop, i_clk, i_rst_n, o_pop |=> r_out_valid)

endmodule

FILE: src/dimmer_command_packet_handler.sv
// Each accepted item is queued in the op FIFO, then executed, and its result registered for the output.
// Throughput: one item per cycle while the output is ready and no address settle is pending.
// After an address write, execution holds while the search delays re-derive.
// Reset (i_rst_n low, synchronous): address 1, paired, no search, queue empty;
// execution starts once the settle counter has run down after reset is released.
`timescale 1ns / 1ps

module dimmer_command_packet_handler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[7:0] pkt_state[15:8] dest_id[47:16] source[55:48] payload[87:56]
    // packet_len[95:88]
    input  logic [95:0]  s_axis_tdata,
    // func[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0] pwm_valid[2] pwm_level[10:3] save_request[11] reply_cmd[19:12]
    // reply_id[51:20] reply_source[59:52] reply_value[61:60] reply_length[69:62]
    // reply_wait_ms[76:70] zero[79:77]
    output logic [79:0]  m_axis_tdata,
    // reply_kind[1:0]
    output logic [1:0]   m_axis_tuser
);
    import dcph_pkg::*;

    t_op   push_op;
    t_op   head_op;
    t_res  res;
    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;

    dcph_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_op    (push_op)
    );

    dcph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_op    (head_op)
    );

    dcph_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (head_valid),
        .i_op        (head_op),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, res.reply_wait_ms, res.reply_length, res.reply_value,
                           res.reply_source, res.reply_id, res.reply_cmd,
                           res.save_request, res.pwm_level, res.pwm_valid, res.status};
    assign m_axis_tuser = res.reply_kind;

endmodule

FILE: tb/dimmer_response_checker.sv
// Response checker for the dimmer command packet handler: predicts one result per input transfer.
// Depends on dcph_pkg for codes and the result struct; watches both stream channels.
`timescale 1ns / 1ps

module dimmer_response_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // cmd[7:0] pkt_state[15:8] dest_id[47:16] source[55:48] payload[87:56]
    // packet_len[95:88]
    input  logic [95:0] i_s_tdata,
    // func[0]
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0] pwm_valid[2] pwm_level[10:3] save_request[11] reply_cmd[19:12]
    // reply_id[51:20] reply_source[59:52] reply_value[61:60] reply_length[69:62]
    // reply_wait_ms[76:70] zero[79:77]
    input  logic [79:0] i_m_tdata,
    // reply_kind[1:0]
    input  logic [1:0]  i_m_tuser,
    output int          o_err_count,
    output int          o_pending
);
    import dcph_pkg::*;

    logic [31:0] own_addr;
    logic [1:0]  pair_state;
    logic        search_on;
    logic [6:0]  search_ticks;
    logic [6:0]  search_rem;
    logic [1:0]  search_lvl;

    t_res expected_responses[$];
    t_res want;
    t_res seen;
    t_res fresh;

    function automatic string res_text(t_res r);
        return $sformatf({"sts=%0d pwm=%0d/%02h save=%0d kind=%0d cmd=%02h id=%08h ",
                          "src=%02h val=%0d len=%0d wait=%0d"},
                         r.status, r.pwm_valid, r.pwm_level, r.save_request, r.reply_kind,
                         r.reply_cmd, r.reply_id, r.reply_source, r.reply_value,
                         r.reply_length, r.reply_wait_ms);
    endfunction

    function automatic bit cmd_known(logic [7:0] c);
        return (c >= CMD_FIRST && c <= CMD_LAST_BASE) || c == CMD_PAIR || c == CMD_SEARCH;
    endfunction

    task automatic predict_response(input logic func, input logic [95:0] d, output t_res r);
        logic [7:0]  cmd;
        logic [7:0]  st;
        logic [7:0]  src;
        logic [7:0]  len;
        logic [7:0]  d0;
        logic [31:0] dest;
        logic [31:0] pay;
        int          dly;
        cmd  = d[7:0];
        st   = d[15:8];
        dest = d[47:16] & ADDR_MASK;
        src  = d[55:48];
        pay  = d[87:56];
        len  = d[95:88];
        d0   = pay[31:24];
        r    = '0;
        if (func) begin
            if (search_on) begin
                if (search_ticks == 7'd0) begin
                    r.reply_kind    = REPLY_SEARCH;
                    r.reply_cmd     = CMD_SEARCH;
                    r.reply_id      = own_addr;
                    r.reply_source  = SRC_BOX;
                    r.reply_value   = search_lvl;
                    r.reply_length  = 8'(5 + ID_BYTES);
                    r.reply_wait_ms = search_rem;
                    search_on       = 1'b0;
                end else begin
                    search_ticks = search_ticks - 7'd1;
                end
            end
        end else if (!cmd_known(cmd)) begin
            r.status = STS_UNSUPPORTED;
        end else if (len < 4 + ID_BYTES) begin
            r.status = STS_SHORT;
        end else if (dest != own_addr && dest != ADDR_MASK) begin
            r.status = STS_NOT_OURS;
        end else begin
            case (cmd)
                CMD_DIM: begin
                    if (st == PKT_CONTROL) begin
                        if (len < 5 + ID_BYTES) begin
                            r.status = STS_SHORT;
                        end else begin
                            r.pwm_valid = 1'b1;
                            r.pwm_level = d0;
                        end
                    end
                end
                CMD_ADDR: begin
                    if (st == PKT_SETUP) begin
                        if (len < 4 + 2 * ID_BYTES) begin
                            r.status = STS_SHORT;
                        end else begin
                            own_addr       = (pay >> (32 - 8 * ID_BYTES)) & ADDR_MASK;
                            r.save_request = 1'b1;
                        end
                    end else if (st == PKT_QUERY) begin
                        r.reply_kind   = REPLY_ADDR;
                        r.reply_cmd    = cmd;
                        r.reply_id     = own_addr;
                        r.reply_source = src;
                        r.reply_length = 8'(4 + 2 * ID_BYTES);
                    end
                end
                CMD_PAIR: begin
                    if (st == PKT_CONTROL) begin
                        if (len < 5 + ID_BYTES) begin
                            r.status = STS_SHORT;
                        end else if (d0 == PAIR_PAIRED || d0 == PAIR_UNPAIRED) begin
                            pair_state     = d0[1:0];
                            r.save_request = 1'b1;
                        end
                    end else if (st == PKT_QUERY) begin
                        r.reply_kind   = REPLY_PAIR;
                        r.reply_cmd    = cmd;
                        r.reply_id     = own_addr;
                        r.reply_source = src;
                        r.reply_value  = pair_state;
                        r.reply_length = 8'(5 + ID_BYTES);
                    end
                end
                CMD_SEARCH: begin
                    if (st == PKT_QUERY && pair_state != PAIR_PAIRED && !search_on &&
                        src != SRC_BT && d0 >= LVL_MINUTE && d0 <= LVL_YEAR) begin
                        if (d0 == LVL_MINUTE)
                            dly = (int'(own_addr[11:6]) * 60 + int'(own_addr[5:0])) * 2;
                        else if (d0 == LVL_DAY)
                            dly = (int'(own_addr[21:17]) * 24 + int'(own_addr[16:12])) * 2;
                        else
                            dly = (int'(own_addr[31:27]) * 12 + int'(own_addr[26:23])) * 2;
                        search_ticks = 7'(dly / 100);
                        search_rem   = 7'(dly % 100);
                        search_lvl   = d0[1:0];
                        search_on    = 1'b1;
                    end
                end
                default: begin
                    r.status = STS_UNSUPPORTED;
                end
            endcase
        end
    endtask

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr     = OWN_ADDR_RESET;
            pair_state   = PAIR_PAIRED;
            search_on    = 1'b0;
            search_ticks = '0;
            search_rem   = '0;
            search_lvl   = '0;
            expected_responses.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.status        = i_m_tdata[1:0];
                seen.pwm_valid     = i_m_tdata[2];
                seen.pwm_level     = i_m_tdata[10:3];
                seen.save_request  = i_m_tdata[11];
                seen.reply_kind    = i_m_tuser;
                seen.reply_cmd     = i_m_tdata[19:12];
                seen.reply_id      = i_m_tdata[51:20];
                seen.reply_source  = i_m_tdata[59:52];
                seen.reply_value   = i_m_tdata[61:60];
                seen.reply_length  = i_m_tdata[69:62];
                seen.reply_wait_ms = i_m_tdata[76:70];
                if (expected_responses.size() == 0) begin
                    o_err_count = o_err_count + 1;
                    if (o_err_count <= 10)
                        $display("%0t: unexpected result %s", $time, res_text(seen));
                end else begin
                    want = expected_responses.pop_front();
                    if (seen !== want || i_m_tdata[79:77] !== 3'b000) begin
                        o_err_count = o_err_count + 1;
                        if (o_err_count <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s pad=0", res_text(want));
                            $display("  actual   %s pad=%0h", res_text(seen), i_m_tdata[79:77]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_response(i_s_tuser, i_s_tdata, fresh);
                expected_responses.push_back(fresh);
            end
        end
        o_pending = expected_responses.size();
    end

endmodule

FILE: tb/tb_dimmer_command_packet_handler.sv
// Testbench top for the dimmer command packet handler: clock, reset, stimulus and verdict.
// Depends on dcph_pkg, the handler RTL and dimmer_response_checker.
`timescale 1ns / 1ps

module tb_dimmer_command_packet_handler;
    import dcph_pkg::*;

    localparam logic [7:0] SRC_REMOTE = 8'h02;
    localparam int RX_HOLD_CYCLES = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // cmd[7:0] pkt_state[15:8] dest_id[47:16] source[55:48] payload[87:56]
    // packet_len[95:88]
    logic [95:0] s_axis_tdata;
    // func[0]
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // status[1:0] pwm_valid[2] pwm_level[10:3] save_request[11] reply_cmd[19:12]
    // reply_id[51:20] reply_source[59:52] reply_value[61:60] reply_length[69:62]
    // reply_wait_ms[76:70] zero[79:77]
    logic [79:0] m_axis_tdata;
    // reply_kind[1:0]
    logic [1:0]  m_axis_tuser;

    int          err_total;
    int          pending_total;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        rx_hold_req;
    logic [31:0] last_setup_addr;
    logic [31:0] addr_pool [5];

    dimmer_command_packet_handler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dimmer_response_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .o_err_count (err_total),
        .o_pending   (pending_total)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, or one long hold counted here.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                for (int n = 1; n < RX_HOLD_CYCLES; n++)
                    @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Call at a falling edge; returns at a falling edge with s_axis_tvalid still driven high.
    task automatic push_item(input logic func, input logic [95:0] body);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= body;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_pkt(input logic [7:0] cmd, input logic [7:0] st,
                            input logic [31:0] dest, input logic [7:0] src,
                            input logic [31:0] pay, input logic [7:0] len);
        push_item(1'b0, {len, pay, src, dest, st, cmd});
    endtask

    task automatic send_tick();
        push_item(1'b1, {$urandom, $urandom, $urandom});
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_total != 0);
    endtask

    task automatic send_random(input int count, input int hold_at);
        logic [7:0]  cmd;
        logic [7:0]  st;
        logic [7:0]  src;
        logic [7:0]  len;
        logic [7:0]  d0;
        logic [31:0] dest;
        logic [31:0] pay;
        int          pick;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                rx_hold_req = 1'b1;
            if ($urandom_range(99) < 25) begin
                send_tick();
            end else begin
                pick = $urandom_range(99);
                if (pick < 20)      cmd = CMD_DIM;
                else if (pick < 35) cmd = CMD_ADDR;
                else if (pick < 55) cmd = CMD_PAIR;
                else if (pick < 80) cmd = CMD_SEARCH;
                else if (pick < 90) cmd = 8'($urandom_range(1, 11));
                else                cmd = 8'($urandom);
                pick = $urandom_range(99);
                if (pick < 40)      st = PKT_CONTROL;
                else if (pick < 75) st = PKT_QUERY;
                else if (pick < 85) st = PKT_SETUP;
                else                st = 8'($urandom);
                pick = $urandom_range(99);
                if (pick < 20)      src = SRC_BT;
                else if (pick < 60) src = SRC_REMOTE;
                else if (pick < 90) src = SRC_BOX;
                else                src = 8'($urandom);
                pick = $urandom_range(99);
                if (pick < 80)      len = 8'($urandom_range(LEN_SETUP, 24));
                else if (pick < 90) len = 8'($urandom_range(0, LEN_SETUP - 1));
                else                len = 8'($urandom);
                pick = $urandom_range(99);
                if (pick < 30)      dest = ADDR_MASK;
                else if (pick < 65) dest = last_setup_addr;
                else if (pick < 80) dest = addr_pool[$urandom_range(4)];
                else                dest = $urandom;
                if (cmd == CMD_PAIR)
                    d0 = ($urandom_range(99) < 80) ? 8'($urandom_range(1, 2)) : 8'($urandom);
                else if (cmd == CMD_SEARCH)
                    d0 = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 4)) : 8'($urandom);
                else
                    d0 = 8'($urandom);
                pay = {d0, 24'($urandom)};
                if (cmd == CMD_ADDR && st == PKT_SETUP) begin
                    pay = ($urandom_range(99) < 70) ? addr_pool[$urandom_range(4)] : $urandom;
                    last_setup_addr = pay;
                end
                send_pkt(cmd, st, dest, src, pay, len);
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        rx_hold_req     = 1'b0;
        tx_idle_pct     = 29;
        rx_idle_pct     = 78;
        last_setup_addr = OWN_ADDR_RESET;
        addr_pool[0]    = 32'h0000_0040;
        addr_pool[1]    = 32'h0002_3000;
        addr_pool[2]    = 32'h0880_0000;
        addr_pool[3]    = 32'h0000_0fff;
        addr_pool[4]    = 32'hffff_ffff;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_tick();
        send_pkt(8'h00, PKT_CONTROL, 32'd1, SRC_REMOTE, 32'h0, 8'd9);
        send_pkt(8'hff, 8'hff, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 8'hff);
        send_pkt(8'h0c, PKT_CONTROL, 32'd1, SRC_REMOTE, 32'h0, 8'd9);
        send_pkt(CMD_DIM, PKT_CONTROL, 32'd1, SRC_REMOTE, 32'h8000_0000, 8'd7);
        send_pkt(CMD_DIM, PKT_CONTROL, 32'd2, SRC_REMOTE, 32'h8000_0000, 8'd9);
        send_pkt(CMD_DIM, PKT_CONTROL, ADDR_MASK, SRC_REMOTE, 32'h8000_0000, 8'd8);
        send_pkt(CMD_DIM, PKT_CONTROL, 32'd1, SRC_BT, 32'hffff_ffff, 8'd9);
        send_pkt(CMD_DIM, PKT_CONTROL, ADDR_MASK, SRC_BOX, 32'h0000_0000, 8'hff);
        send_pkt(CMD_DIM, PKT_QUERY, 32'd1, SRC_REMOTE, 32'h7f00_0000, 8'd9);
        send_pkt(CMD_FIRST, PKT_CONTROL, 32'd1, SRC_REMOTE, 32'h0, 8'd9);
        send_pkt(CMD_LAST_BASE, PKT_QUERY, ADDR_MASK, SRC_REMOTE, 32'h0, 8'd9);
        send_pkt(CMD_ADDR, PKT_QUERY, 32'd1, SRC_REMOTE, 32'h0, 8'd8);
        send_pkt(CMD_PAIR, PKT_QUERY, 32'd1, SRC_BOX, 32'h0, 8'd8);
        send_pkt(CMD_SEARCH, PKT_QUERY, ADDR_MASK, SRC_REMOTE, 32'h0100_0000, 8'd9);
        send_pkt(CMD_PAIR, PKT_CONTROL, 32'd1, SRC_REMOTE, 32'h0300_0000, 8'd9);
        send_pkt(CMD_PAIR, PKT_CONTROL, 32'd1, SRC_REMOTE, 32'h0200_0000, 8'd8);
        send_pkt(CMD_ADDR, PKT_SETUP, 32'd1, SRC_REMOTE, 32'h0000_0040, 8'd11);
        send_pkt(CMD_ADDR, PKT_SETUP, 32'd1, SRC_REMOTE, 32'h0000_0040, 8'd12);
        send_pkt(CMD_PAIR, PKT_CONTROL, 32'h40, SRC_REMOTE, 32'h0200_0000, 8'd9);
        send_pkt(CMD_SEARCH, PKT_QUERY, ADDR_MASK, SRC_BT, 32'h0100_0000, 8'd9);
        send_pkt(CMD_SEARCH, PKT_QUERY, ADDR_MASK, SRC_REMOTE, 32'h0400_0000, 8'd9);
        send_pkt(CMD_SEARCH, PKT_QUERY, 32'h40, SRC_REMOTE, 32'h0100_0000, 8'd9);
        send_pkt(CMD_SEARCH, PKT_QUERY, 32'h40, SRC_BOX, 32'h0300_0000, 8'd9);
        send_tick();
        send_tick();
        send_pkt(CMD_PAIR, PKT_QUERY, 32'h40, SRC_REMOTE, 32'h0, 8'd9);
        send_pkt(CMD_PAIR, PKT_CONTROL, 32'h40, SRC_REMOTE, 32'h0100_0000, 8'd9);
        last_setup_addr = 32'h0000_0040;
        wait_drained();

        send_random(633, -1);
        wait_drained();

        tx_idle_pct = 78;
        rx_idle_pct = 29;
        send_random(633, -1);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(634, 100);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (err_total == 0 && pending_total == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
